### design/e2q_pkg.sv
// Shared constants, types and the CORDIC angle table for the Euler to quaternion core.
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int RUN_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int XW = 33;   // CORDIC x/y, Q30 with headroom
    localparam int ZW = 30;   // angle accumulator, 2^-20 degree units
    localparam int TW = 32;   // clamped sine/cosine, Q30, holds +-1.0 exactly
    localparam int PW = 62;   // full products
    localparam int SW = 63;   // sum of two triple products

    localparam logic signed [XW-1:0] GAIN_Q30     = XW'(652032874);
    localparam logic signed [XW-1:0] ONE_Q30      = XW'(1073741824);
    localparam logic signed [16:0]   QUARTER_TURN = 17'sd11520;
    localparam logic signed [16:0]   HALF_TURN    = 17'sd23040;
    localparam logic signed [16:0]   OUT_MAX      = 17'sd16384;

    typedef logic signed [TW-1:0] trig_t;
    typedef logic signed [15:0]   comp_t;

    // atan(2^-i) in 2^-20 degree units
    function automatic logic signed [ZW-1:0] atan_deg20(input int i);
        logic signed [ZW-1:0] v;
        v = '0;
        case (i)
            0:  v = ZW'(47185920);
            1:  v = ZW'(27855475);
            2:  v = ZW'(14718068);
            3:  v = ZW'(7471121);
            4:  v = ZW'(3750058);
            5:  v = ZW'(1876857);
            6:  v = ZW'(938658);
            7:  v = ZW'(469357);
            8:  v = ZW'(234682);
            9:  v = ZW'(117342);
            10: v = ZW'(58671);
            11: v = ZW'(29335);
            12: v = ZW'(14668);
            13: v = ZW'(7334);
            14: v = ZW'(3667);
            15: v = ZW'(1833);
            16: v = ZW'(917);
            17: v = ZW'(458);
            18: v = ZW'(229);
            19: v = ZW'(115);
            20: v = ZW'(57);
            21: v = ZW'(29);
            22: v = ZW'(14);
            23: v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

### design/e2q_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine of one half angle.
`timescale 1ns / 1ps
module e2q_cordic (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [15:0]   angle,
    output e2q_pkg::trig_t       cos_val,
    output e2q_pkg::trig_t       sin_val
);
    import e2q_pkg::*;

    logic signed [XW-1:0] x_reg [0:RUN_STAGES];
    logic signed [XW-1:0] y_reg [0:RUN_STAGES];
    logic signed [ZW-1:0] z_reg [0:RUN_STAGES];
    logic                 flip_reg [0:RUN_STAGES];
    trig_t                cos_reg, sin_reg;

    logic signed [16:0]   h_red;
    logic                 flip_next;

    // the input is already the half angle in 1/128 degree units
    always_comb
    begin
        h_red     = 17'(angle);
        flip_next = 1'b0;
        if (17'(angle) > QUARTER_TURN)
        begin
            h_red     = 17'(angle) - HALF_TURN;
            flip_next = 1'b1;
        end
        else if (17'(angle) < -QUARTER_TURN)
        begin
            h_red     = 17'(angle) + HALF_TURN;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= ZW'(h_red) <<< 13;
            flip_reg[0] <= flip_next;
            for (int i = 0; i < RUN_STAGES; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_deg20(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_deg20(i);
                end
            end
        end
    end

    logic signed [XW-1:0] xc, yc;

    always_comb
    begin
        xc = x_reg[RUN_STAGES];
        yc = y_reg[RUN_STAGES];
        if (xc > ONE_Q30)  xc = ONE_Q30;
        if (xc < -ONE_Q30) xc = -ONE_Q30;
        if (yc > ONE_Q30)  yc = ONE_Q30;
        if (yc < -ONE_Q30) yc = -ONE_Q30;
        if (flip_reg[RUN_STAGES])
        begin
            xc = -xc;
            yc = -yc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= TW'(xc);
            sin_reg <= TW'(yc);
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;
endmodule

### design/euler_to_quaternion_core.sv
// Top level: Euler angles to scalar-first Q1.14 quaternion, fully pipelined.
//
//  channel | dir | tdata fields (lowest bit first)
//  s_axis  | in  | roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
//  m_axis  | out | q_scalar[15:0], q_x[31:16], q_y[47:32], q_z[63:48]
//
// One item per cycle while the output is not stalled; the pipeline is the
// unrolled CORDIC chain plus reduce, clamp, pair, triple and sum stages.
// rst_n clears only the valid bits; the pipeline holds as a whole while an
// output item waits and m_axis_tready is low, so nothing is lost or repeated.
`timescale 1ns / 1ps
module euler_to_quaternion_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // q_scalar, q_x, q_y, q_z
);
    import e2q_pkg::*;

    localparam int LAT = RUN_STAGES + 5;

    logic           en;
    logic [LAT-1:0] valid_reg;
    trig_t          cr, sr, cp, sp, cy, sy;

    assign en            = m_axis_tready | ~valid_reg[LAT-1];
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
    end

    e2q_cordic u_roll  (.clk(clk), .en(en), .angle(s_axis_tdata[15:0]),
                        .cos_val(cr), .sin_val(sr));
    e2q_cordic u_pitch (.clk(clk), .en(en), .angle(s_axis_tdata[31:16]),
                        .cos_val(cp), .sin_val(sp));
    e2q_cordic u_yaw   (.clk(clk), .en(en), .angle(s_axis_tdata[47:32]),
                        .cos_val(cy), .sin_val(sy));

    // pair products, rounded back to Q30
    logic signed [PW-1:0] crcp_p, srsp_p, srcp_p, crsp_p;
    trig_t crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    trig_t cy_reg, sy_reg;

    assign crcp_p = (PW'(cr) * PW'(cp) + PW'(64'sd536870912)) >>> 30;
    assign srsp_p = (PW'(sr) * PW'(sp) + PW'(64'sd536870912)) >>> 30;
    assign srcp_p = (PW'(sr) * PW'(cp) + PW'(64'sd536870912)) >>> 30;
    assign crsp_p = (PW'(cr) * PW'(sp) + PW'(64'sd536870912)) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crcp_reg <= TW'(crcp_p);
            srsp_reg <= TW'(srsp_p);
            srcp_reg <= TW'(srcp_p);
            crsp_reg <= TW'(crsp_p);
            cy_reg   <= cy;
            sy_reg   <= sy;
        end
    end

    // triple products, Q60
    logic signed [PW-1:0] t_ccc_reg, t_sss_reg, t_scc_reg, t_css_reg;
    logic signed [PW-1:0] t_csc_reg, t_scs_reg, t_ccs_reg, t_ssc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_ccc_reg <= PW'(crcp_reg) * PW'(cy_reg);
            t_sss_reg <= PW'(srsp_reg) * PW'(sy_reg);
            t_scc_reg <= PW'(srcp_reg) * PW'(cy_reg);
            t_css_reg <= PW'(crsp_reg) * PW'(sy_reg);
            t_csc_reg <= PW'(crsp_reg) * PW'(cy_reg);
            t_scs_reg <= PW'(srcp_reg) * PW'(sy_reg);
            t_ccs_reg <= PW'(crcp_reg) * PW'(sy_reg);
            t_ssc_reg <= PW'(srsp_reg) * PW'(cy_reg);
        end
    end

    function automatic comp_t to_q14(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] r;
        logic signed [16:0]   v;
        r = (s + SW'(64'sd35184372088832)) >>> 46;
        v = 17'(r);
        if (v > OUT_MAX)  v = OUT_MAX;
        if (v < -OUT_MAX) v = -OUT_MAX;
        return comp_t'(v[15:0]);
    endfunction

    comp_t q_scalar_reg, q_x_reg, q_y_reg, q_z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_scalar_reg <= to_q14(SW'(t_ccc_reg) + SW'(t_sss_reg));
            q_x_reg      <= to_q14(SW'(t_scc_reg) - SW'(t_css_reg));
            q_y_reg      <= to_q14(SW'(t_csc_reg) + SW'(t_scs_reg));
            q_z_reg      <= to_q14(SW'(t_ccs_reg) - SW'(t_ssc_reg));
        end
    end

    assign m_axis_tvalid = valid_reg[LAT-1];
    assign m_axis_tdata  = {q_z_reg, q_y_reg, q_x_reg, q_scalar_reg};
endmodule

### design/e2q_checker.sv
// Port-level checks for the Euler to quaternion core, bound to the top level.
`timescale 1ns / 1ps
module e2q_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_taken: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[15:0])  <= 16384 && $signed(m_axis_tdata[15:0])  >= -16384 &&
             $signed(m_axis_tdata[31:16]) <= 16384 && $signed(m_axis_tdata[31:16]) >= -16384 &&
             $signed(m_axis_tdata[47:32]) <= 16384 && $signed(m_axis_tdata[47:32]) >= -16384 &&
             $signed(m_axis_tdata[63:48]) <= 16384 && $signed(m_axis_tdata[63:48]) >= -16384))
        else $error("component outside saturation range");
endmodule

bind euler_to_quaternion_core e2q_checker u_e2q_checker (.*);
